// ===== sv/abu_pkg.sv =====
// Package for the block audio unfilter: predictor mode codes, block
// layout constants and the shared sample-history type. No dependencies.
package abu_pkg;

    // Predictor mode codes carried by the first byte of each block
    localparam logic [2:0] MODE_ZERO   = 3'd0;
    localparam logic [2:0] MODE_LAST   = 3'd1;
    localparam logic [2:0] MODE_HALF   = 3'd2;
    localparam logic [2:0] MODE_LINEAR = 3'd3;
    localparam logic [2:0] MODE_QUAD   = 3'd4;

    // Block layout: mode byte, seeds, then residuals
    localparam int BLOCK_SAMPLES_DEF = 256;
    localparam int SEED_COUNT        = 3;

    // Last three decoded samples (c newest, a oldest)
    typedef struct packed {
        logic [7:0] oldest;
        logic [7:0] middle;
        logic [7:0] newest;
    } t_hist;

endpackage

// ===== sv/audio_block_unfilter_top.sv =====
// Top level of the block audio unfilter: input register, decode state,
// result register. Depends on abu_pkg and abu_predict.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one byte of the filtered
//   stream per beat, with i_stream_start marking the first byte of a stream.
//   Each block is one mode byte, three seed bytes and BLOCK_SAMPLES-3
//   residual bytes. Every byte except the mode byte yields one result beat
//   on the output channel (o_out_valid / i_out_ready) carrying the sample,
//   a flag on the block's last sample and the running residual sum.
//   Path: an accepted byte is held in the input register, then its result
//   in the result register (registered input, then registered result).
//   Throughput: one byte per cycle, sustained while the receiver takes
//   results; the decode state updates with the result register.
//   Receiver stall: the result register holds its beat; one more byte may
//   sit in the input register, after which o_in_ready drops until the
//   result is taken.
//   Reset: both registers empty, decode position at the mode byte, mode,
//   sample history and residual sum cleared.
module audio_block_unfilter_top #(
    parameter int BLOCK_SAMPLES = abu_pkg::BLOCK_SAMPLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_stream_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_sample,
    output logic        o_block_last,
    output logic [31:0] o_residual_sum
);
    import abu_pkg::*;

    localparam int PW = $clog2(BLOCK_SAMPLES + 1);

    // Input register
    logic        r_in_valid, n_in_valid;
    logic [7:0]  r_byte;
    logic        r_start;

    // Decode state
    logic [PW-1:0] r_pos, n_pos;
    logic [2:0]    r_mode, n_mode;
    t_hist         r_hist, n_hist;
    logic [31:0]   r_total, n_total;

    // Result register
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_sample, n_sample;
    logic        r_last, n_last;

    logic          fire;
    logic [PW-1:0] pos_eff;
    logic [31:0]   total_eff;
    logic [32:0]   total_sum;
    logic [7:0]    pred_sample;
    logic [7:0]    dec_sample;
    logic          is_mode, is_seed;

    // Stage advances when the result register can take a beat
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign n_in_valid = o_in_ready ? i_in_valid : r_in_valid;

    abu_predict u_predict (
        .i_mode     (r_mode),
        .i_hist     (r_hist),
        .i_residual (r_byte),
        .o_sample   (pred_sample)
    );

    // Decode: stream start clears position and sum before the byte is used
    always_comb begin
        pos_eff    = r_start ? '0 : r_pos;
        total_eff  = r_start ? 32'd0 : r_total;
        is_mode    = (pos_eff == '0);
        is_seed    = (pos_eff <= PW'(SEED_COUNT));
        total_sum  = {1'b0, total_eff} + {25'd0, r_byte};
        dec_sample = is_seed ? r_byte : pred_sample;

        n_pos       = r_pos;
        n_mode      = r_mode;
        n_hist      = r_hist;
        n_total     = r_total;
        n_sample    = r_sample;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_out_ready;

        if (fire) begin
            n_total = total_eff;
            if (is_mode) begin
                n_mode = (r_byte <= {5'd0, MODE_QUAD}) ? r_byte[2:0] : MODE_ZERO;
                n_pos  = PW'(1);
            end else begin
                if (!is_seed) begin
                    n_total = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
                end
                n_hist.oldest = r_hist.middle;
                n_hist.middle = r_hist.newest;
                n_hist.newest = dec_sample;
                n_sample      = dec_sample;
                n_out_valid   = 1'b1;
                n_last        = (pos_eff >= PW'(BLOCK_SAMPLES));
                n_pos         = n_last ? '0 : pos_eff + PW'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_mode      <= MODE_ZERO;
            r_hist      <= '0;
            r_total     <= 32'd0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
            r_mode      <= n_mode;
            r_hist      <= n_hist;
            r_total     <= n_total;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_byte  <= i_in_byte;
            r_start <= i_stream_start;
        end
        r_sample <= n_sample;
        r_last   <= n_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample       = r_sample;
    assign o_block_last   = r_last;
    assign o_residual_sum = r_total;

endmodule

// ===== sv/abu_predict.sv =====
// Prediction and residual reconstruction for one residual byte.
// Depends on abu_pkg (mode codes, t_hist).
module abu_predict (
    input  logic [2:0]     i_mode,
    input  abu_pkg::t_hist i_hist,
    input  logic [7:0]     i_residual,
    output logic [7:0]     o_sample
);
    import abu_pkg::*;

    logic signed [11:0] a, b, c;
    logic signed [11:0] raw;
    logic signed [11:0] half;
    logic [7:0]         pred;
    logic [7:0]         mag;
    logic [15:0]        square;

    // Raw prediction, wide enough for 3c-3b+a
    always_comb begin
        a    = {4'd0, i_hist.oldest};
        b    = {4'd0, i_hist.middle};
        c    = {4'd0, i_hist.newest};
        half = 12'sd3 * c - b;
        case (i_mode)
            MODE_LAST:   raw = c;
            MODE_HALF:   raw = half[11] ? 12'sd0 : (half >>> 1);
            MODE_LINEAR: raw = 12'sd2 * c - b;
            MODE_QUAD:   raw = 12'sd3 * c - 12'sd3 * b + a;
            default:     raw = 12'sd0;
        endcase
    end

    // Clamp to 0..255
    always_comb begin
        if (raw[11]) begin
            pred = 8'd0;
        end else if (raw > 12'sd255) begin
            pred = 8'd255;
        end else begin
            pred = raw[7:0];
        end
    end

    // Signed residual adds or subtracts its square, modulo 256
    always_comb begin
        mag      = i_residual[7] ? (8'd0 - i_residual) : i_residual;
        square   = mag * mag;
        o_sample = i_residual[7] ? (pred - square[7:0]) : (pred + square[7:0]);
    end

endmodule

// ===== sv/abu_checker.sv =====
// Port-level checks for the block audio unfilter, bound to the top level.
// Depends on audio_block_unfilter_top's port list only.
module abu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_sample,
    input logic        o_block_last,
    input logic [31:0] o_residual_sum
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample)
            && $stable(o_block_last) && $stable(o_residual_sum))
        else $error("result beat changed while stalled");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // With no result pending the block always takes input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // Output empty and no input, then again no input: the input register has
    // drained, so once the result is gone nothing new appears
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !i_in_valid ##1 !i_in_valid && (!o_out_valid || i_out_ready)
            |=> !o_out_valid)
        else $error("result appeared without input");

endmodule

bind audio_block_unfilter_top abu_checker u_abu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_sample       (o_sample),
    .o_block_last   (o_block_last),
    .o_residual_sum (o_residual_sum)
);
